FILE: src/uvs_pkg.sv
package uvs_pkg;

  localparam int unsigned FracBits  = 14;
  localparam int unsigned RomDepth  = 1024;
  localparam int unsigned RomWidth  = FracBits + 1;
  localparam int unsigned TermCount = 14;

  localparam logic [63:0] PiQ60    = 64'h3243_F6A8_885A_308D;
  localparam logic [15:0] AngleQtr = 16'h4000;
  localparam logic [16:0] TexMax   = 17'd65536;

  // Reciprocals of the Taylor divisors (2t)(2t+1), scaled by 2^64.
  localparam logic [63:0] RecipOne = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TermRecip [TermCount] = '{
    RecipOne / 64'd6,   RecipOne / 64'd20,  RecipOne / 64'd42,  RecipOne / 64'd72,
    RecipOne / 64'd110, RecipOne / 64'd156, RecipOne / 64'd210, RecipOne / 64'd272,
    RecipOne / 64'd342, RecipOne / 64'd420, RecipOne / 64'd506, RecipOne / 64'd600,
    RecipOne / 64'd702, RecipOne / 64'd812
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DIVISION_COUNT = 2'd0,
    REG_STACK_STEP     = 2'd1,
    REG_COUNT_RECIP    = 2'd2
  } cfg_reg_e;

  // Integer results that travel alongside the trigonometry.
  typedef struct packed {
    logic        err;
    logic        has_cell;
    logic        upper;
    logic        lower;
    logic [12:0] vi;
    logic [12:0] k1;
    logic [12:0] k2;
    logic [16:0] ts;
    logic [16:0] tt;
  } side_t;

  typedef logic [RomWidth-1:0] sine_rom_t [RomDepth];

  // Upper 64 bits of a 128-bit product, shifted for Q62 operands.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [63:0] msk, al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    msk = 64'h0000_0000_FFFF_FFFF;
    al  = a & msk;
    ah  = a >> 32;
    bl  = b & msk;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & msk) + (hl & msk);
    lo  = (mid << 32) | (ll & msk);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // Truncating quotient of a term by its Taylor divisor. The scaled reciprocal
  // gives the quotient or one less, and a single correction step settles it.
  function automatic logic [63:0] div_term(logic [63:0] num, int t);
    logic [127:0] wide;
    logic [63:0]  quo, dvs, rem;
    dvs  = 64'((2 * t) * (2 * t + 1));
    wide = 128'(num) * 128'(TermRecip[t-1]);
    quo  = wide[127:64];
    rem  = num - quo * dvs;
    if (rem >= dvs) begin
      quo = quo + 64'd1;
    end
    return quo;
  endfunction

  // Quarter-wave sine table evaluated by a Taylor series in Q62 at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] stp, x, x2, term, sum, rnd;
    stp = PiQ60 >> 9;
    rnd = 64'd1 << (61 - FracBits);
    for (int k = 0; k < RomDepth; k++) begin
      x    = 64'(k) * stp;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int t = 1; t <= TermCount; t++) begin
        term = div_term(mul_q62(term, x2), t);
        if ((t & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rom[k] = RomWidth'((sum + rnd) >> (62 - FracBits));
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

FILE: src/uvs_sine_unit.sv
module uvs_sine_unit (
  input  logic               clk_i,
  input  logic               look_en_i,
  input  logic               sign_en_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] value_o
);

  logic [1:0]                     quad;
  logic [9:0]                     m;
  logic [9:0]                     idx;
  logic [uvs_pkg::RomWidth-1:0]   entry_q;
  logic [1:0]                     quad_q;
  logic                           mzero_q;
  logic [uvs_pkg::RomWidth-1:0]   base;
  logic signed [15:0]             mag;
  logic signed [15:0]             value_d;
  logic signed [15:0]             value_q;

  assign quad = angle_i[15:14];
  assign m    = angle_i[13:4];
  // Odd quadrants run the table backwards.
  assign idx  = quad[0] ? 10'(11'd1024 - {1'b0, m}) : m;

  always_ff @(posedge clk_i) begin
    if (look_en_i) begin
      entry_q <= uvs_pkg::SineRom[idx];
      quad_q  <= quad;
      mzero_q <= (m == 10'd0);
    end
  end

  // The peak of an odd quadrant lies one past the end of the table.
  assign base    = (quad_q[0] && mzero_q) ?
                   uvs_pkg::RomWidth'(1 << uvs_pkg::FracBits) : entry_q;
  assign mag     = signed'(16'(base));
  assign value_d = quad_q[1] ? -mag : mag;

  always_ff @(posedge clk_i) begin
    if (sign_en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

FILE: src/uvs_lattice_stage.sv
module uvs_lattice_stage (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [6:0]          stack_index_i,
  input  logic [6:0]          sector_index_i,
  input  logic [6:0]          div_count_i,
  input  logic [15:0]         step_i,
  input  logic [15:0]         recip_i,
  output uvs_pkg::side_t      side_o,
  output logic [15:0]         angle_a_o,
  output logic [15:0]         angle_b_o
);

  logic [7:0]      np1;
  logic [14:0]     vi_full;
  logic [14:0]     k2_full;
  logic [22:0]     step_i_prod;
  logic [22:0]     step_j_prod;
  logic [22:0]     tex_i_prod;
  logic [22:0]     tex_j_prod;
  logic            err;
  logic            has_cell;
  uvs_pkg::side_t  side_d;
  uvs_pkg::side_t  side_q;
  logic [15:0]     angle_a_q;
  logic [15:0]     angle_b_q;

  assign np1         = {1'b0, div_count_i} + 8'd1;
  assign vi_full     = 15'(stack_index_i) * 15'(np1) + 15'(sector_index_i);
  assign k2_full     = vi_full + 15'(np1);
  assign step_i_prod = 23'(stack_index_i) * 23'(step_i);
  assign step_j_prod = 23'(sector_index_i) * 23'(step_i);
  assign tex_i_prod  = 23'(stack_index_i) * 23'(recip_i);
  assign tex_j_prod  = 23'(sector_index_i) * 23'(recip_i);

  assign err      = (stack_index_i > div_count_i) || (sector_index_i > div_count_i);
  assign has_cell = !err && (stack_index_i < div_count_i) && (sector_index_i < div_count_i);

  always_comb begin
    side_d          = '0;
    side_d.err      = err;
    side_d.has_cell = has_cell;
    side_d.upper    = has_cell && (stack_index_i != 7'd0);
    side_d.lower    = has_cell && (stack_index_i != (div_count_i - 7'd1));
    if (!err) begin
      side_d.vi = vi_full[12:0];
      side_d.ts = (tex_j_prod > 23'(uvs_pkg::TexMax)) ? uvs_pkg::TexMax : tex_j_prod[16:0];
      side_d.tt = (tex_i_prod > 23'(uvs_pkg::TexMax)) ? uvs_pkg::TexMax : tex_i_prod[16:0];
    end
    if (has_cell) begin
      side_d.k1 = vi_full[12:0];
      side_d.k2 = k2_full[12:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q    <= side_d;
      angle_a_q <= uvs_pkg::AngleQtr - step_i_prod[15:0];
      angle_b_q <= {step_j_prod[14:0], 1'b0};
    end
  end

  assign side_o    = side_q;
  assign angle_a_o = angle_a_q;
  assign angle_b_o = angle_b_q;

endmodule

FILE: src/uv_sphere_vertex_generator_unit.sv
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// input    | in        | in_valid_i/in_stall_o | stack_index_i, sector_index_i
// output   | out       | out_valid_o/out_stall_i | vertex_index_o, pos_*_o, tex_*_o, flags, corners
// config   | in        | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One transaction is taken every cycle unless a stall at the output raises in_stall_o.
// The pipeline has four stages: index arithmetic, sine table read,
// quadrant sign, and the rounded cosine products.
// Reset clears the valid bits of every stage and loads the default configuration.
// A stall holds only the stages that carry a valid transaction; empty stages still fill.
module uv_sphere_vertex_generator_unit #(
  parameter int unsigned MAX_DIVISIONS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [6:0]         stack_index_i,
  input  logic [6:0]         sector_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [12:0]        vertex_index_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [16:0]        tex_s_o,
  output logic [16:0]        tex_t_o,
  output logic               cell_present_o,
  output logic               upper_tri_valid_o,
  output logic               lower_tri_valid_o,
  output logic [12:0]        corner_top_o,
  output logic [12:0]        corner_bottom_o,
  output logic               range_error_o
);

  localparam logic [8:0] MaxDiv = 9'(MAX_DIVISIONS);

  logic [6:0]          div_count_q;
  logic [15:0]         step_q;
  logic [15:0]         recip_q;
  logic [6:0]          div_sat;

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                en1, en2, en3, en4;

  uvs_pkg::side_t      side1;
  uvs_pkg::side_t      side2_q;
  uvs_pkg::side_t      side3_q;
  uvs_pkg::side_t      side4_q;
  logic [15:0]         angle_a;
  logic [15:0]         angle_b;

  logic signed [15:0]  cos_a;
  logic signed [15:0]  sin_a;
  logic signed [15:0]  cos_b;
  logic signed [15:0]  sin_b;
  logic signed [31:0]  prod_x;
  logic signed [31:0]  prod_y;
  logic signed [31:0]  round_x;
  logic signed [31:0]  round_y;
  logic signed [15:0]  pos_x_q;
  logic signed [15:0]  pos_y_q;
  logic signed [15:0]  pos_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_count_q <= 7'd8;
      step_q      <= 16'd4096;
      recip_q     <= 16'd8192;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uvs_pkg::REG_DIVISION_COUNT: div_count_q <= cfg_wdata_i[6:0];
        uvs_pkg::REG_STACK_STEP:     step_q      <= cfg_wdata_i;
        uvs_pkg::REG_COUNT_RECIP:    recip_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign div_sat = ({2'b00, div_count_q} > MaxDiv) ? MaxDiv[6:0] : div_count_q;

  // A stage moves when it is empty or when the stage after it moves.
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  uvs_lattice_stage u_lattice (
    .clk_i          (clk_i),
    .en_i           (en1),
    .stack_index_i  (stack_index_i),
    .sector_index_i (sector_index_i),
    .div_count_i    (div_sat),
    .step_i         (step_q),
    .recip_i        (recip_q),
    .side_o         (side1),
    .angle_a_o      (angle_a),
    .angle_b_o      (angle_b)
  );

  // The cosine is the sine a quarter turn further on.
  uvs_sine_unit u_cos_a (
    .clk_i     (clk_i),
    .look_en_i (en2),
    .sign_en_i (en3),
    .angle_i   (angle_a + uvs_pkg::AngleQtr),
    .value_o   (cos_a)
  );

  uvs_sine_unit u_sin_a (
    .clk_i     (clk_i),
    .look_en_i (en2),
    .sign_en_i (en3),
    .angle_i   (angle_a),
    .value_o   (sin_a)
  );

  uvs_sine_unit u_cos_b (
    .clk_i     (clk_i),
    .look_en_i (en2),
    .sign_en_i (en3),
    .angle_i   (angle_b + uvs_pkg::AngleQtr),
    .value_o   (cos_b)
  );

  uvs_sine_unit u_sin_b (
    .clk_i     (clk_i),
    .look_en_i (en2),
    .sign_en_i (en3),
    .angle_i   (angle_b),
    .value_o   (sin_b)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      side2_q <= side1;
    end
    if (en3) begin
      side3_q <= side2_q;
    end
  end

  // Round to nearest with ties towards positive infinity.
  assign prod_x  = cos_a * cos_b;
  assign prod_y  = cos_a * sin_b;
  assign round_x = prod_x + 32'sd8192;
  assign round_y = prod_y + 32'sd8192;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      side4_q <= side3_q;
      pos_x_q <= side3_q.err ? 16'sd0 : round_x[29:14];
      pos_y_q <= side3_q.err ? 16'sd0 : round_y[29:14];
      pos_z_q <= side3_q.err ? 16'sd0 : sin_a;
    end
  end

  assign out_valid_o       = v4_q;
  assign vertex_index_o    = side4_q.vi;
  assign pos_x_o           = pos_x_q;
  assign pos_y_o           = pos_y_q;
  assign pos_z_o           = pos_z_q;
  assign tex_s_o           = side4_q.ts;
  assign tex_t_o           = side4_q.tt;
  assign cell_present_o    = side4_q.has_cell;
  assign upper_tri_valid_o = side4_q.upper;
  assign lower_tri_valid_o = side4_q.lower;
  assign corner_top_o      = side4_q.k1;
  assign corner_bottom_o   = side4_q.k2;
  assign range_error_o     = side4_q.err;

endmodule
